// ===== hw/rtl/btx_pkg.sv =====
// Package: shared constants, codes, types and character tests of the token scanner.
`default_nettype none

package btx_pkg;

  localparam int unsigned MAX_DEPTH = 255;
  localparam int unsigned POS_WIDTH = 32;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUOTED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BODY    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BARE    = 3'd4;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_WORD   = 4'd1;
  localparam logic [3:0] K_STRING = 4'd2;
  localparam logic [3:0] K_OPEN   = 4'd3;
  localparam logic [3:0] K_CLOSE  = 4'd4;
  localparam logic [3:0] K_EQUALS = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_AT     = 4'd7;
  localparam logic [3:0] K_HASH   = 4'd8;
  localparam logic [3:0] K_ERROR  = 4'd9;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_END_BODY  = 2'd1;
  localparam logic [1:0] ERR_TOO_DEEP  = 2'd2;
  localparam logic [1:0] ERR_UNMATCHED = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  err;
    logic [31:0] tok_start;
    logic [31:0] tok_end;
    logic        last;
  } btx_token_t;

  typedef struct packed {
    logic [1:0] n;
    btx_token_t tok0;
    btx_token_t tok1;
  } btx_push_t;

  typedef struct packed {
    logic stuck;
    logic fire;
  } btx_status_t;

  function automatic logic is_white(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_NL;
  endfunction

  function automatic logic ends_bare(input logic [7:0] c);
    return c == CH_NUL || is_white(c) || c == CH_AT || c == CH_PCT || c == CH_EQUALS ||
           c == CH_COMMA || c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic btx_token_t mk_tok(input logic [3:0] kind, input logic [1:0] err,
                                        input logic [POS_WIDTH-1:0] s,
                                        input logic [POS_WIDTH-1:0] e);
    btx_token_t t;
    t.kind      = kind;
    t.err       = err;
    t.tok_start = 32'(s);
    t.tok_end   = 32'(e);
    t.last      = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/btx_byte_if.sv =====
// Interface: input byte channel with valid/ready handshake.
`default_nettype none

interface btx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/btx_token_if.sv =====
// Interface: token result channel with valid/ready handshake.
`default_nettype none

interface btx_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [1:0]  error_kind;
  logic [31:0] token_start;
  logic [31:0] token_end;
  logic        last_of_step;

  modport source (output valid, output token_kind, output error_kind, output token_start,
                  output token_end, output last_of_step, input ready);
  modport sink (input valid, input token_kind, input error_kind, input token_start,
                input token_end, input last_of_step, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bibtex_token_scanner_top.sv =====
// Top level: BibTeX token scanner, byte stream in, token stream out.
// A byte accepted into the input register is decoded there, and its tokens go to the token queue.
// One byte per cycle while the queue has room; a byte with two tokens takes two queue entries.
// Rate is set by the four-entry token queue, which the core fills only with room for two.
// Reset clears scan state, offsets, input register and queue at once; no clearing pass.
`default_nettype none

module bibtex_token_scanner_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  btx_byte_if.sink  text_i,
  btx_token_if.source tok_o
);
  import btx_pkg::*;

  btx_push_t        push;
  btx_status_t      status;
  btx_token_t       head;
  logic             room;
  logic             out_valid;
  logic [CNT_W-1:0] count;

  btx_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (text_i.valid),
    .in_byte_i  (text_i.text_byte),
    .room_i     (room),
    .in_ready_o (text_i.ready),
    .push_o     (push),
    .status_o   (status)
  );

  btx_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (tok_o.ready),
    .room_o  (room),
    .valid_o (out_valid),
    .head_o  (head),
    .count_o (count)
  );

  assign tok_o.valid        = out_valid;
  assign tok_o.token_kind   = head.kind;
  assign tok_o.error_kind   = head.err;
  assign tok_o.token_start  = head.tok_start;
  assign tok_o.token_end    = head.tok_end;
  assign tok_o.last_of_step = head.last;

`ifndef SYNTHESIS
  a_stuck_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.stuck |=> status.stuck)
    else $error("stuck flag cleared without reset");

  a_no_tokens_when_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.fire && status.stuck) |-> (push.n == 2'd0))
    else $error("token produced while stuck");

  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> status.fire)
    else $error("token pushed without a consumed byte");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("token queue overflow");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/btx_core.sv =====
// Scanner core: input register, scan state and per-byte token decode.
`default_nettype none

module btx_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               room_i,
  output logic                    in_ready_o,
  output btx_pkg::btx_push_t      push_o,
  output btx_pkg::btx_status_t    status_o
);
  import btx_pkg::*;

  logic                 vld_q, vld_d;
  logic [7:0]           byte_q;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic                 entry_q, entry_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] rs_q, rs_d;
  logic                 rfl_q, rfl_d;
  logic                 stuck_q, stuck_d;

  logic                 fire;
  logic                 run_bw;
  logic                 pre_v, bw_v;
  btx_token_t           pre_tok, bw_tok;
  logic [POS_WIDTH-1:0] nxt;
  logic [7:0]           c;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;
  assign c          = byte_q;
  assign nxt        = pos_q + POS_WIDTH'(1);

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (fire) begin
      vld_d = 1'b0;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    entry_d = entry_q;
    depth_d = depth_q;
    rs_d    = rs_q;
    rfl_d   = rfl_q;
    stuck_d = stuck_q;
    run_bw  = 1'b0;
    pre_v   = 1'b0;
    bw_v    = 1'b0;
    pre_tok = mk_tok(K_STRING, ERR_NONE, rs_q, pos_q);
    bw_tok  = mk_tok(K_END, ERR_NONE, pos_q, pos_q);

    if (!stuck_q) begin
      unique case (mode_q)
        MODE_COMMENT: begin
          run_bw = (c == CH_NL) || (c == CH_NUL);
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            pre_v  = 1'b1;
            mode_d = MODE_BETWEEN;
          end else if (c == CH_NUL) begin
            pre_v  = 1'b1;
            run_bw = 1'b1;
          end
        end
        MODE_BODY: begin
          if (c == CH_NUL) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(K_ERROR, ERR_END_BODY, pos_q, pos_q);
            stuck_d = 1'b1;
          end else if (c == CH_LBRACE) begin
            if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
              pre_v   = 1'b1;
              pre_tok = mk_tok(K_ERROR, ERR_TOO_DEEP, pos_q, pos_q);
              stuck_d = 1'b1;
            end else begin
              depth_d = depth_q + DEPTH_W'(1);
            end
          end else if (c == CH_RBRACE) begin
            if (depth_q <= DEPTH_W'(1)) begin
              depth_d = '0;
              pre_v   = 1'b1;
              mode_d  = MODE_BETWEEN;
            end else begin
              depth_d = depth_q - DEPTH_W'(1);
            end
          end
        end
        MODE_BARE: begin
          if (ends_bare(c)) begin
            pre_v   = 1'b1;
            pre_tok = mk_tok(rfl_q ? K_WORD : K_STRING, ERR_NONE, rs_q, pos_q);
            run_bw  = 1'b1;
          end
        end
        default: begin
          run_bw = 1'b1;
        end
      endcase

      if (run_bw) begin
        mode_d = MODE_BETWEEN;
        if (!is_white(c)) begin
          unique case (c)
            CH_NUL: begin
              bw_v = 1'b1;
            end
            CH_PCT: begin
              mode_d = MODE_COMMENT;
            end
            CH_LBRACE: begin
              if (entry_q) begin
                mode_d  = MODE_BODY;
                depth_d = DEPTH_W'(1);
                rs_d    = nxt;
              end else begin
                entry_d = 1'b1;
                bw_v    = 1'b1;
                bw_tok  = mk_tok(K_OPEN, ERR_NONE, pos_q, nxt);
              end
            end
            CH_RBRACE: begin
              bw_v = 1'b1;
              if (!entry_q) begin
                bw_tok  = mk_tok(K_ERROR, ERR_UNMATCHED, pos_q, pos_q);
                stuck_d = 1'b1;
              end else begin
                entry_d = 1'b0;
                bw_tok  = mk_tok(K_CLOSE, ERR_NONE, pos_q, nxt);
              end
            end
            CH_EQUALS: begin
              bw_v   = 1'b1;
              bw_tok = mk_tok(K_EQUALS, ERR_NONE, pos_q, nxt);
            end
            CH_COMMA: begin
              bw_v   = 1'b1;
              bw_tok = mk_tok(K_COMMA, ERR_NONE, pos_q, nxt);
            end
            CH_AT: begin
              bw_v   = 1'b1;
              bw_tok = mk_tok(K_AT, ERR_NONE, pos_q, nxt);
            end
            CH_HASH: begin
              bw_v   = 1'b1;
              bw_tok = mk_tok(K_HASH, ERR_NONE, pos_q, nxt);
            end
            CH_QUOTE: begin
              mode_d = MODE_QUOTED;
              rs_d   = nxt;
            end
            default: begin
              mode_d = MODE_BARE;
              rs_d   = pos_q;
              rfl_d  = is_letter(c);
            end
          endcase
        end
      end
    end

    pos_d = stuck_d ? pos_q : nxt;
  end

  always_comb begin
    push_o.n    = fire ? (2'(pre_v) + 2'(bw_v)) : 2'd0;
    push_o.tok0 = pre_v ? pre_tok : bw_tok;
    push_o.tok1 = bw_tok;
    push_o.tok0.last = !(pre_v && bw_v);
    push_o.tok1.last = 1'b1;
  end

  assign status_o.stuck = stuck_q;
  assign status_o.fire  = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      entry_q <= 1'b0;
      depth_q <= '0;
      pos_q   <= '0;
      rs_q    <= '0;
      rfl_q   <= 1'b0;
      stuck_q <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      entry_q <= entry_d;
      depth_q <= depth_d;
      pos_q   <= pos_d;
      rs_q    <= rs_d;
      rfl_q   <= rfl_d;
      stuck_q <= stuck_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/btx_tok_fifo.sv =====
// Token queue: takes up to two tokens per cycle, delivers one per cycle while the reader is ready.
`default_nettype none

module btx_tok_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  btx_pkg::btx_push_t     push_i,
  input  wire logic              pop_i,
  output logic                   room_o,
  output logic                   valid_o,
  output btx_pkg::btx_token_t    head_o,
  output logic [btx_pkg::CNT_W-1:0] count_o
);
  import btx_pkg::*;

  btx_token_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.n);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_bibtex_token_scanner_top.sv =====
// Testbench for the BibTeX token scanner: random and directed byte streams, token-level checking.
module tb_bibtex_token_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btx_pkg::*;

  class token_scoreboard;
    btx_token_t tokens_due[$];
    logic [MODE_W-1:0] mode = MODE_BETWEEN;
    logic entry_open = 1'b0;
    int unsigned depth = 0;
    logic [POS_WIDTH-1:0] byte_pos = '0;
    logic [POS_WIDTH-1:0] run_start = '0;
    logic run_alpha = 1'b0;
    logic stuck = 1'b0;
    int unsigned mismatches = 0;
    int unsigned tokens_checked = 0;
    int unsigned kind_seen[10];

    function bit is_space(logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_NL};
    endfunction

    function bit stops_run(logic [7:0] c);
      return is_space(c) || (c inside {CH_NUL, CH_AT, CH_PCT, CH_EQUALS, CH_COMMA,
                                       CH_LBRACE, CH_RBRACE, CH_QUOTE});
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function void push_token(logic [3:0] kind, logic [1:0] err,
                             logic [POS_WIDTH-1:0] s, logic [POS_WIDTH-1:0] e);
      btx_token_t t;
      t.kind      = kind;
      t.err       = err;
      t.tok_start = 32'(s);
      t.tok_end   = 32'(e);
      t.last      = 1'b0;
      tokens_due.push_back(t);
    endfunction

    function void raise_error(logic [1:0] err, logic [POS_WIDTH-1:0] pos);
      push_token(K_ERROR, err, pos, pos);
      stuck = 1'b1;
    endfunction

    function void step_between(logic [7:0] c, logic [POS_WIDTH-1:0] pos);
      logic [POS_WIDTH-1:0] nxt;
      nxt = pos + 1'b1;
      mode = MODE_BETWEEN;
      if (is_space(c)) return;
      case (c)
        CH_NUL: push_token(K_END, ERR_NONE, pos, pos);
        CH_PCT: mode = MODE_COMMENT;
        CH_LBRACE: begin
          if (entry_open) begin
            mode = MODE_BODY;
            depth = 1;
            run_start = nxt;
          end else begin
            entry_open = 1'b1;
            push_token(K_OPEN, ERR_NONE, pos, nxt);
          end
        end
        CH_RBRACE: begin
          if (!entry_open) begin
            raise_error(ERR_UNMATCHED, pos);
          end else begin
            entry_open = 1'b0;
            push_token(K_CLOSE, ERR_NONE, pos, nxt);
          end
        end
        CH_EQUALS: push_token(K_EQUALS, ERR_NONE, pos, nxt);
        CH_COMMA:  push_token(K_COMMA, ERR_NONE, pos, nxt);
        CH_AT:     push_token(K_AT, ERR_NONE, pos, nxt);
        CH_HASH:   push_token(K_HASH, ERR_NONE, pos, nxt);
        CH_QUOTE: begin
          mode = MODE_QUOTED;
          run_start = nxt;
        end
        default: begin
          mode = MODE_BARE;
          run_start = pos;
          run_alpha = is_alpha(c);
        end
      endcase
    endfunction

    // Predict the tokens caused by one accepted byte.
    function void scan_byte(logic [7:0] c);
      logic [POS_WIDTH-1:0] pos;
      int n_before;
      if (stuck) return;
      pos = byte_pos;
      n_before = tokens_due.size();
      case (mode)
        MODE_COMMENT: begin
          if (c == CH_NL || c == CH_NUL) step_between(c, pos);
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            push_token(K_STRING, ERR_NONE, run_start, pos);
            mode = MODE_BETWEEN;
          end else if (c == CH_NUL) begin
            push_token(K_STRING, ERR_NONE, run_start, pos);
            step_between(c, pos);
          end
        end
        MODE_BODY: begin
          if (c == CH_NUL) begin
            raise_error(ERR_END_BODY, pos);
          end else if (c == CH_LBRACE) begin
            if (depth >= MAX_DEPTH) raise_error(ERR_TOO_DEEP, pos);
            else depth++;
          end else if (c == CH_RBRACE) begin
            if (depth <= 1) begin
              depth = 0;
              push_token(K_STRING, ERR_NONE, run_start, pos);
              mode = MODE_BETWEEN;
            end else begin
              depth--;
            end
          end
        end
        MODE_BARE: begin
          if (stops_run(c)) begin
            push_token(run_alpha ? K_WORD : K_STRING, ERR_NONE, run_start, pos);
            step_between(c, pos);
          end
        end
        default: step_between(c, pos);
      endcase
      if (!stuck) byte_pos = pos + 1'b1;
      if (tokens_due.size() > n_before) tokens_due[tokens_due.size()-1].last = 1'b1;
    endfunction

    function bit would_stick(logic [7:0] c);
      if (stuck) return 1'b0;
      case (mode)
        MODE_BODY:    return c == CH_NUL || (c == CH_LBRACE && depth >= MAX_DEPTH);
        MODE_BETWEEN: return c == CH_RBRACE && !entry_open;
        MODE_BARE:    return c == CH_RBRACE && !entry_open;
        default:      return 1'b0;
      endcase
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("%0t ns: token mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task match_token(btx_token_t got);
      btx_token_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected token kind %0d start %0d end %0d",
                         got.kind, got.tok_start, got.tok_end));
        return;
      end
      want = tokens_due.pop_front();
      tokens_checked++;
      if (want.kind < 10) kind_seen[want.kind]++;
      if (got.kind !== want.kind || got.err !== want.err || got.tok_start !== want.tok_start ||
          got.tok_end !== want.tok_end || got.last !== want.last)
        report($sformatf("got k%0d e%0d [%0d,%0d) l%0b, want k%0d e%0d [%0d,%0d) l%0b",
                         got.kind, got.err, got.tok_start, got.tok_end, got.last,
                         want.kind, want.err, want.tok_start, want.tok_end, want.last));
    endtask

    task finish_check();
      if (tokens_due.size() != 0)
        report($sformatf("%0d tokens never arrived", tokens_due.size()));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  btx_byte_if  bif();
  btx_token_if tif();

  bibtex_token_scanner_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (bif),
    .tok_o  (tif)
  );

  token_scoreboard sb = new();

  int src_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  logic [7:0] text_q[$];

  logic [7:0] intro[25] = '{CH_AT, "a", CH_HASH, "1", CH_LBRACE, 8'h0d, CH_EQUALS, "k",
                            CH_COMMA, CH_TAB, CH_LBRACE, CH_LBRACE, CH_RBRACE, CH_RBRACE,
                            CH_QUOTE, 8'hff, CH_NUL, CH_PCT, CH_NUL, CH_RBRACE, CH_VT,
                            CH_FF, CH_NL, "Z", CH_SPACE};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_bibtex_token_scanner_top failed");
    $finish;
  end

  // Token sink: checks accepted items, stalls at random, one long hold-off on request.
  initial begin
    int hold_left;
    btx_token_t got;
    hold_left = 0;
    tif.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (tif.valid === 1'b1 && tif.ready) begin
        got.kind      = tif.token_kind;
        got.err       = tif.error_kind;
        got.tok_start = tif.token_start;
        got.tok_end   = tif.token_end;
        got.last      = tif.last_of_step;
        sb.match_token(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        tif.ready <= 1'b0;
      end else begin
        tif.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_raw(input logic [7:0] c);
    if ($urandom_range(99) < src_idle_pct) begin
      bif.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    bif.valid <= 1'b1;
    bif.text_byte <= c;
    do @(posedge clk_i); while (bif.ready !== 1'b1);
    sb.scan_byte(c);
    bytes_sent++;
  endtask

  // Keeps the random part clear of the sticky error states.
  task automatic send_text(input logic [7:0] c);
    if (sb.would_stick(c)) c = (c == CH_RBRACE) ? CH_LBRACE : 8'h78;
    send_raw(c);
  endtask

  function automatic void put(logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void put_ws();
    repeat ($urandom_range(2)) begin
      case ($urandom_range(5))
        0: put(CH_TAB);
        1: put(CH_NL);
        2: put(CH_VT);
        3: put(CH_FF);
        default: put(CH_SPACE);
      endcase
    end
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic void put_name();
    put(rand_letter());
    repeat ($urandom_range(5)) begin
      case ($urandom_range(3))
        0: put(8'("0" + $urandom_range(9)));
        1: put("_");
        default: put(rand_letter());
      endcase
    end
  endfunction

  function automatic void put_braced(int level);
    logic [7:0] c;
    put(CH_LBRACE);
    repeat ($urandom_range(6)) begin
      if (level < 3 && $urandom_range(5) == 0) begin
        put_braced(level + 1);
      end else begin
        c = $urandom_range(7) == 0 ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
        if (c == CH_LBRACE || c == CH_RBRACE) c = "b";
        put(c);
      end
    end
    put(CH_RBRACE);
  endfunction

  function automatic void put_quoted();
    logic [7:0] c;
    put(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      c = $urandom_range(7) == 0 ? 8'($urandom_range(1, 255)) : 8'($urandom_range(32, 126));
      if (c == CH_QUOTE) c = "q";
      put(c);
    end
    put(CH_QUOTE);
  endfunction

  function automatic void put_value();
    case ($urandom_range(3))
      0: put_braced(0);
      1: put_quoted();
      2: repeat ($urandom_range(1, 4)) put(8'("0" + $urandom_range(9)));
      default: put_name();
    endcase
    if ($urandom_range(4) == 0) begin
      put_ws();
      put(CH_HASH);
      put_ws();
      put_value();
    end
  endfunction

  function automatic void put_entry();
    int n_fields;
    n_fields = $urandom_range(3);
    put(CH_AT);
    put_name();
    put_ws();
    put(CH_LBRACE);
    put_name();
    put(CH_COMMA);
    for (int i = 0; i < n_fields; i++) begin
      put_ws();
      put_name();
      put_ws();
      put(CH_EQUALS);
      put_ws();
      put_value();
      if (i < n_fields - 1 || $urandom_range(1)) put(CH_COMMA);
    end
    put_ws();
    put(CH_RBRACE);
    put(CH_NL);
  endfunction

  function automatic void put_chunk();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      put_entry();
    end else if (pick < 72) begin
      put(CH_PCT);
      repeat ($urandom_range(8)) put(8'($urandom_range(1, 255)));
      put(CH_NL);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) put_quoted();
      else put_name();
      put(CH_NUL);
    end
  endfunction

  initial begin
    int target;
    int waited;
    logic [1:0] closing_err;
    bif.valid = 1'b0;
    bif.text_byte = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (intro[i]) send_text(intro[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
        1: begin src_idle_pct = 65; stall_pct = 0;  end
        2: begin src_idle_pct = 0;  stall_pct = 65; end
        default: begin src_idle_pct = 36; stall_pct = 36; end
      endcase
      target = bytes_sent + 240;
      while (bytes_sent < target) begin
        put_chunk();
        while (text_q.size() > 0) send_text(text_q.pop_front());
      end
    end

    // The run closes on one sticky error, then checks that further bytes stay silent.
    while (!(sb.mode == MODE_BETWEEN && !sb.entry_open)) begin
      case (sb.mode)
        MODE_QUOTED:  send_raw(CH_QUOTE);
        MODE_COMMENT: send_raw(CH_NL);
        MODE_BARE:    send_raw(CH_SPACE);
        default:      send_raw(CH_RBRACE);
      endcase
    end
    closing_err = 2'($urandom_range(1, 3));
    case (closing_err)
      ERR_UNMATCHED: send_raw(CH_RBRACE);
      ERR_END_BODY: begin
        send_raw(CH_LBRACE);
        send_raw(CH_LBRACE);
        send_raw(CH_NUL);
      end
      default: begin
        send_raw(CH_LBRACE);
        send_raw(CH_LBRACE);
        repeat (MAX_DEPTH) send_raw(CH_LBRACE);
      end
    endcase
    repeat (16) send_raw(8'($urandom_range(255)));
    bif.valid <= 1'b0;

    waited = 0;
    while (sb.tokens_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    sb.finish_check();

    $display("run covered %0d bytes and %0d tokens (%0d words, %0d strings, %0d end marks)",
             bytes_sent, sb.tokens_checked, sb.kind_seen[K_WORD], sb.kind_seen[K_STRING],
             sb.kind_seen[K_END]);
    $display("four idle/stall phases, one long output hold-off, closing error code %0d",
             closing_err);
    if (sb.mismatches == 0) begin
      $display("tb_bibtex_token_scanner_top passed");
    end else begin
      $display("tb_bibtex_token_scanner_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/btx_pkg.sv
hw/rtl/btx_byte_if.sv
hw/rtl/btx_token_if.sv
hw/rtl/btx_core.sv
hw/rtl/btx_tok_fifo.sv
hw/rtl/bibtex_token_scanner_top.sv
tb/tb_bibtex_token_scanner_top.sv
